/* hdl/chash_pkg.sv */
// Shared constants, codes and controller/datapath command and status types
// for the chained hash table. Depends on nothing.
`timescale 1ns / 1ps

package chash_pkg;

    localparam int BUCKETS = 16;
    localparam int NODES   = 256;

    localparam int KIND_W  = 2;
    localparam int KEY_W   = 31;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;

    // A pointer holds a node index or the null value NODES.
    localparam int PTR_W   = $clog2(NODES + 1);
    localparam int NODE_W  = $clog2(NODES);
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int STEP_W  = $clog2(NODES + 1);

    localparam logic [PTR_W-1:0]  PTR_NULL  = PTR_W'(NODES);
    localparam logic [STEP_W-1:0] STEP_MAX  = STEP_W'(NODES);

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic load;        // latch the request and fetch its bucket head
        logic rd_free;     // read the node at the free-list head
        logic ins_commit;  // fill the free node and push it onto the chain
        logic advance;     // step the walk to the next node
        logic unlink;      // splice the matched node out of its chain
        logic free_node;   // push the matched node onto the free list
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              free_empty;
        logic              walk_end;
        logic              key_match;
        logic [VAL_W-1:0]  rd_value;
    } stat_t;

endpackage

/* hdl/chash_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on chash_pkg for field widths.
`timescale 1ns / 1ps

interface chash_req_if;
    logic                           valid;
    logic                           ready;
    logic [chash_pkg::KIND_W-1:0]   kind;
    logic [chash_pkg::KEY_W-1:0]    key;
    logic signed [chash_pkg::VAL_W-1:0] value;

    modport source (output valid, output kind, output key, output value, input ready);
    modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface chash_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [chash_pkg::STAT_W-1:0]       status;
    logic signed [chash_pkg::VAL_W-1:0] found_value;

    modport source (output valid, output status, output found_value, input ready);
    modport sink   (input valid, input status, input found_value, output ready);
endinterface

/* hdl/chash_datapath.sv */
// Datapath: bucket heads, node memories, free list and chain walk pointers.
// Depends on chash_pkg; driven by chash_ctrl through cmd_t and stat_t.
`timescale 1ns / 1ps

module chash_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [chash_pkg::KIND_W-1:0] in_kind,
    input  logic [chash_pkg::KEY_W-1:0]  in_key,
    input  logic [chash_pkg::VAL_W-1:0]  in_value,
    input  chash_pkg::cmd_t              cmd,
    output chash_pkg::stat_t             stat
);

    logic [chash_pkg::KIND_W-1:0] kind_reg;
    logic [chash_pkg::KEY_W-1:0]  key_reg;
    logic [chash_pkg::VAL_W-1:0]  value_reg;

    logic [chash_pkg::PTR_W-1:0]  head_reg [chash_pkg::BUCKETS];
    logic [chash_pkg::PTR_W-1:0]  free_head_reg;
    logic [chash_pkg::PTR_W-1:0]  cur_reg;
    logic [chash_pkg::PTR_W-1:0]  prev_reg;
    logic [chash_pkg::STEP_W-1:0] steps_reg;

    logic [chash_pkg::KEY_W-1:0]  key_mem   [chash_pkg::NODES];
    logic [chash_pkg::VAL_W-1:0]  value_mem [chash_pkg::NODES];
    logic [chash_pkg::PTR_W-1:0]  next_mem  [chash_pkg::NODES];
    logic [chash_pkg::NODES-1:0]  next_valid_reg;

    logic [chash_pkg::KEY_W-1:0]  key_rd_reg;
    logic [chash_pkg::VAL_W-1:0]  value_rd_reg;
    logic [chash_pkg::PTR_W-1:0]  next_rd_reg;
    logic                         nvalid_rd_reg;
    logic [chash_pkg::NODE_W-1:0] rd_addr_reg;

    logic [chash_pkg::BKT_W-1:0]  in_bkt;
    logic [chash_pkg::BKT_W-1:0]  bkt;
    logic [chash_pkg::NODE_W-1:0] rd_addr;
    logic [chash_pkg::PTR_W-1:0]  next_rd;
    logic                         prev_ok;
    logic                         nw_en;
    logic [chash_pkg::NODE_W-1:0] nw_addr;
    logic [chash_pkg::PTR_W-1:0]  nw_data;

    // The bucket count is a power of two, so the modulo is the low key bits.
    assign in_bkt  = in_key[chash_pkg::BKT_W-1:0];
    assign bkt     = key_reg[chash_pkg::BKT_W-1:0];
    assign prev_ok = (prev_reg < chash_pkg::PTR_NULL);

    // Reads are only used when the selected pointer is a real node.
    assign rd_addr = cmd.rd_free ? free_head_reg[chash_pkg::NODE_W-1:0]
                                 : cur_reg[chash_pkg::NODE_W-1:0];

    // A link never written reads as the next node index through its valid bit.
    assign next_rd = nvalid_rd_reg ? next_rd_reg
                                   : chash_pkg::PTR_W'(rd_addr_reg) + chash_pkg::PTR_W'(1);

    always_comb
    begin
        nw_en   = 1'b0;
        nw_addr = cur_reg[chash_pkg::NODE_W-1:0];
        nw_data = free_head_reg;
        if (cmd.ins_commit)
        begin
            nw_en   = 1'b1;
            nw_addr = free_head_reg[chash_pkg::NODE_W-1:0];
            nw_data = head_reg[bkt];
        end
        else if (cmd.unlink && prev_ok)
        begin
            nw_en   = 1'b1;
            nw_addr = prev_reg[chash_pkg::NODE_W-1:0];
            nw_data = next_rd;
        end
        else if (cmd.free_node)
        begin
            nw_en   = 1'b1;
            nw_addr = cur_reg[chash_pkg::NODE_W-1:0];
            nw_data = free_head_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= in_kind;
            key_reg   <= in_key;
            value_reg <= in_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_commit)
        begin
            key_mem[free_head_reg[chash_pkg::NODE_W-1:0]]   <= key_reg;
            value_mem[free_head_reg[chash_pkg::NODE_W-1:0]] <= value_reg;
        end
        if (nw_en)
        begin
            next_mem[nw_addr] <= nw_data;
        end
        key_rd_reg   <= key_mem[rd_addr];
        value_rd_reg <= value_mem[rd_addr];
        next_rd_reg  <= next_mem[rd_addr];
        rd_addr_reg  <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_valid_reg <= '0;
            nvalid_rd_reg  <= 1'b0;
        end
        else
        begin
            if (nw_en)
            begin
                next_valid_reg[nw_addr] <= 1'b1;
            end
            nvalid_rd_reg <= next_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < chash_pkg::BUCKETS; i++)
            begin
                head_reg[i] <= chash_pkg::PTR_NULL;
            end
            free_head_reg <= '0;
            cur_reg       <= chash_pkg::PTR_NULL;
            prev_reg      <= chash_pkg::PTR_NULL;
            steps_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                cur_reg   <= head_reg[in_bkt];
                prev_reg  <= chash_pkg::PTR_NULL;
                steps_reg <= '0;
            end
            if (cmd.advance)
            begin
                prev_reg  <= cur_reg;
                cur_reg   <= next_rd;
                steps_reg <= steps_reg + chash_pkg::STEP_W'(1);
            end
            if (cmd.ins_commit)
            begin
                head_reg[bkt] <= free_head_reg;
                free_head_reg <= next_rd;
            end
            if (cmd.unlink && !prev_ok)
            begin
                head_reg[bkt] <= next_rd;
            end
            if (cmd.free_node)
            begin
                free_head_reg <= cur_reg;
            end
        end
    end

    assign stat.kind       = kind_reg;
    assign stat.free_empty = (free_head_reg >= chash_pkg::PTR_NULL);
    assign stat.walk_end   = (cur_reg >= chash_pkg::PTR_NULL) || (steps_reg == chash_pkg::STEP_MAX);
    assign stat.key_match  = (key_rd_reg == key_reg);
    assign stat.rd_value   = value_rd_reg;

endmodule

/* hdl/chash_ctrl.sv */
// Controller: sequences one request at a time and holds the response register.
// Depends on chash_pkg; drives chash_datapath through cmd_t.
`timescale 1ns / 1ps

module chash_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [chash_pkg::KIND_W-1:0]  in_kind,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [chash_pkg::STAT_W-1:0]  out_status,
    output logic [chash_pkg::VAL_W-1:0]   out_value,
    output chash_pkg::cmd_t               cmd,
    input  chash_pkg::stat_t              stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_READ,
        S_INS_WRITE,
        S_WALK,
        S_CHECK,
        S_FREE,
        S_FINISH
    } state_t;

    state_t                        state_reg;
    logic [chash_pkg::STAT_W-1:0]  res_status_reg;
    logic [chash_pkg::VAL_W-1:0]   res_value_reg;
    logic                          out_valid_reg;
    logic [chash_pkg::STAT_W-1:0]  out_status_reg;
    logic [chash_pkg::VAL_W-1:0]   out_value_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.load       = (state_reg == S_IDLE) && in_valid;
        cmd.rd_free    = (state_reg == S_INS_READ);
        cmd.ins_commit = (state_reg == S_INS_WRITE);
        cmd.advance    = (state_reg == S_CHECK) && !stat.key_match;
        cmd.unlink     = (state_reg == S_CHECK) && stat.key_match
                         && (stat.kind == chash_pkg::KIND_REMOVE);
        cmd.free_node  = (state_reg == S_FREE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_status_reg <= chash_pkg::ST_MISS;
            res_value_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= chash_pkg::ST_MISS;
            out_value_reg  <= '0;
        end
        else
        begin
            // The finishing state reloads the response register itself.
            if (out_valid_reg && out_ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        res_value_reg <= '0;
                        unique case (in_kind)
                            chash_pkg::KIND_INSERT: state_reg <= S_INS_READ;
                            chash_pkg::KIND_LOOKUP: state_reg <= S_WALK;
                            chash_pkg::KIND_REMOVE: state_reg <= S_WALK;
                            default:
                            begin
                                res_status_reg <= chash_pkg::ST_MISS;
                                state_reg      <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_INS_READ:
                begin
                    if (stat.free_empty)
                    begin
                        res_status_reg <= chash_pkg::ST_FULL;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_INS_WRITE;
                    end
                end
                S_INS_WRITE:
                begin
                    res_status_reg <= chash_pkg::ST_OK;
                    state_reg      <= S_FINISH;
                end
                S_WALK:
                begin
                    if (stat.walk_end)
                    begin
                        res_status_reg <= chash_pkg::ST_MISS;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (!stat.key_match)
                    begin
                        state_reg <= S_WALK;
                    end
                    else if (stat.kind == chash_pkg::KIND_LOOKUP)
                    begin
                        res_status_reg <= chash_pkg::ST_OK;
                        res_value_reg  <= stat.rd_value;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_FREE;
                    end
                end
                S_FREE:
                begin
                    res_status_reg <= chash_pkg::ST_OK;
                    state_reg      <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_value_reg  <= res_value_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;

endmodule

/* hdl/chained_hash_table_top.sv */
// Top level of the chained hash table: joins the controller and datapath
// to the request and response channels. Depends on chash_pkg, chash_if,
// chash_ctrl and chash_datapath.
`timescale 1ns / 1ps

//  channel | dir | payload                         | role
//  --------+-----+---------------------------------+-------------------------
//  req     | in  | kind, key, value                | insert, lookup or remove
//  rsp     | out | status, found_value             | one beat per request
//
//  Requests are served one at a time. An insert reads the free-list head,
//  then commits the node, or ends with a full status when the pool is empty;
//  a lookup or remove walks the bucket chain to a key match or the chain end,
//  and a remove that hits unlinks the node, then frees it; an unused kind
//  ends with a miss status. Each node visited passes a walk state for the
//  registered read of the node memories and a check state to compare and
//  step, since all node memories share one read port. Reset is asynchronous
//  and needs no clearing pass: the bucket heads reset to empty and per-node
//  link valid bits make unwritten links read as the next node. A finished
//  response waits in the output register; a stalled rsp only holds the block
//  in its final state, and the next request is taken as soon as the response
//  register has room.

module chained_hash_table_top (
    input  logic        clk,
    input  logic        rst_n,
    chash_req_if.sink   req,
    chash_rsp_if.source rsp
);

    chash_pkg::cmd_t               cmd;
    chash_pkg::stat_t              stat;
    logic [chash_pkg::STAT_W-1:0]  rsp_status;
    logic [chash_pkg::VAL_W-1:0]   rsp_value;

    // The controller sequences each request and owns both handshakes.
    chash_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .in_kind    (req.kind),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_status (rsp_status),
        .out_value  (rsp_value),
        .cmd        (cmd),
        .stat       (stat)
    );

    // The datapath holds the table itself and the chain walk pointers.
    chash_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_kind  (req.kind),
        .in_key   (req.key),
        .in_value (req.value),
        .cmd      (cmd),
        .stat     (stat)
    );

    assign rsp.status      = rsp_status;
    assign rsp.found_value = rsp_value;

`ifndef SYNTHESIS
    // Only one request is in flight, so ready must drop after an accept.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another is in flight");

    // A nonzero value can only come back from a successful lookup.
    a_value_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.found_value != 0)) |-> (rsp.status == chash_pkg::ST_OK))
        else $error("found_value set on a response that is not a hit");

    // The response status is always one of the defined codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.status == chash_pkg::ST_OK)
                    || (rsp.status == chash_pkg::ST_MISS)
                    || (rsp.status == chash_pkg::ST_FULL)))
        else $error("undefined response status");
`endif

endmodule
